>>> hdl/murc_pkg.sv
// package for the modem unsolicited result code byte matcher
// holds the match patterns, parse phases, shared types and the matcher step function
// no dependencies
package murc_pkg;

    localparam int CAPTURE_BYTES = 24;
    localparam int CNT_W         = $clog2(CAPTURE_BYTES);
    localparam int PAT_MAX       = 11;

    localparam logic [3:0] RING_LEN = 4'd5;
    localparam logic [3:0] LONG_LEN = 4'd11;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [3:0] END_STATUS = 4'd6;

    typedef logic [7:0] t_pat [PAT_MAX];

    localparam t_pat PAT_RING_CR = '{"R", "I", "N", "G", CHAR_CR,
                                     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam t_pat PAT_RING_LF = '{"R", "I", "N", "G", CHAR_LF,
                                     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam t_pat PAT_NOC_CR  = '{"N", "O", " ", "C", "A", "R", "R", "I", "E", "R",
                                     CHAR_CR};
    localparam t_pat PAT_NOC_LF  = '{"N", "O", " ", "C", "A", "R", "R", "I", "E", "R",
                                     CHAR_LF};
    localparam t_pat PAT_UCS     = '{"+", "U", "C", "A", "L", "L", "S", "T", "A", "T",
                                     ":"};

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_AFTER_COMMA,
        PH_DIGIT,
        PH_ACCEPT,
        PH_REJECT
    } t_phase;

    typedef struct packed {
        logic       hit;
        logic [3:0] pos;
    } t_mstep;

    typedef struct packed {
        logic ring;
        logic nocarrier;
        logic callstat;
    } t_match_evt;

    function automatic t_mstep match_step(input t_pat pat, input logic [3:0] len,
                                          input logic [3:0] pos, input logic [7:0] b);
        t_mstep     res;
        logic [3:0] p;
        p   = (pos >= len) ? 4'd0 : pos;
        res = '0;
        if (b == pat[p]) begin
            if ((p + 4'd1) >= len) begin
                res.hit = 1'b1;
                res.pos = 4'd0;
            end else begin
                res.pos = p + 4'd1;
            end
        end else begin
            res.pos = (b == pat[0]) ? 4'd1 : 4'd0;
        end
        return res;
    endfunction

endpackage

>>> hdl/murc_matchers.sv
// five literal pattern matchers with their position registers
// depends on murc_pkg
module murc_matchers (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [7:0]            i_byte,
    output murc_pkg::t_match_evt  o_evt
);

    logic [2:0] r_ring_cr_pos, n_ring_cr_pos;
    logic [2:0] r_ring_lf_pos, n_ring_lf_pos;
    logic [3:0] r_noc_cr_pos, n_noc_cr_pos;
    logic [3:0] r_noc_lf_pos, n_noc_lf_pos;
    logic [3:0] r_ucs_pos, n_ucs_pos;

    murc_pkg::t_mstep ring_cr, ring_lf, noc_cr, noc_lf, ucs;

    always_comb begin
        ring_cr = murc_pkg::match_step(murc_pkg::PAT_RING_CR, murc_pkg::RING_LEN,
                                       {1'b0, r_ring_cr_pos}, i_byte);
        ring_lf = murc_pkg::match_step(murc_pkg::PAT_RING_LF, murc_pkg::RING_LEN,
                                       {1'b0, r_ring_lf_pos}, i_byte);
        noc_cr  = murc_pkg::match_step(murc_pkg::PAT_NOC_CR, murc_pkg::LONG_LEN,
                                       r_noc_cr_pos, i_byte);
        noc_lf  = murc_pkg::match_step(murc_pkg::PAT_NOC_LF, murc_pkg::LONG_LEN,
                                       r_noc_lf_pos, i_byte);
        ucs     = murc_pkg::match_step(murc_pkg::PAT_UCS, murc_pkg::LONG_LEN,
                                       r_ucs_pos, i_byte);
    end

    always_comb begin
        n_ring_cr_pos = r_ring_cr_pos;
        n_ring_lf_pos = r_ring_lf_pos;
        n_noc_cr_pos  = r_noc_cr_pos;
        n_noc_lf_pos  = r_noc_lf_pos;
        n_ucs_pos     = r_ucs_pos;
        if (i_en) begin
            n_ring_cr_pos = ring_cr.pos[2:0];
            // lf twin holds when the cr pattern completes
            if (!ring_cr.hit) begin
                n_ring_lf_pos = ring_lf.pos[2:0];
            end
            n_noc_cr_pos = noc_cr.pos;
            if (!noc_cr.hit) begin
                n_noc_lf_pos = noc_lf.pos;
            end
            n_ucs_pos = ucs.pos;
        end
    end

    always_comb begin
        o_evt.ring      = i_en && (ring_cr.hit || ring_lf.hit);
        o_evt.nocarrier = i_en && (noc_cr.hit || noc_lf.hit);
        o_evt.callstat  = i_en && ucs.hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_cr_pos <= '0;
            r_ring_lf_pos <= '0;
            r_noc_cr_pos  <= '0;
            r_noc_lf_pos  <= '0;
            r_ucs_pos     <= '0;
        end else begin
            r_ring_cr_pos <= n_ring_cr_pos;
            r_ring_lf_pos <= n_ring_lf_pos;
            r_noc_cr_pos  <= n_noc_cr_pos;
            r_noc_lf_pos  <= n_noc_lf_pos;
            r_ucs_pos     <= n_ucs_pos;
        end
    end

endmodule

>>> hdl/murc_capture.sv
// call status payload capture and incremental parser
// depends on murc_pkg
module murc_capture (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    input  logic        i_start,
    output logic        o_capturing,
    output logic        o_status_valid,
    output logic [3:0]  o_call_status,
    output logic        o_status_end
);

    logic                       r_capturing, n_capturing;
    logic [murc_pkg::CNT_W-1:0] r_count, n_count;
    murc_pkg::t_phase           r_phase, n_phase;
    logic [3:0]                 r_digit, n_digit;

    logic is_term, is_blank, is_digit, is_comma, room;

    assign is_term  = (i_byte == murc_pkg::CHAR_CR) || (i_byte == murc_pkg::CHAR_LF);
    assign is_blank = (i_byte == murc_pkg::CHAR_SPACE) || (i_byte == murc_pkg::CHAR_TAB);
    assign is_comma = (i_byte == murc_pkg::CHAR_COMMA);
    assign is_digit = (i_byte >= murc_pkg::CHAR_ZERO) && (i_byte <= murc_pkg::CHAR_NINE);
    assign room     = r_count < murc_pkg::CNT_W'(murc_pkg::CAPTURE_BYTES - 1);

    always_comb begin
        n_capturing = r_capturing;
        n_count     = r_count;
        n_phase     = r_phase;
        n_digit     = r_digit;
        if (i_en) begin
            if (r_capturing) begin
                if (is_term) begin
                    n_capturing = 1'b0;
                    n_count     = '0;
                    n_phase     = murc_pkg::PH_SEEK;
                    n_digit     = '0;
                end else if (room) begin
                    n_count = r_count + 1'b1;
                    unique case (r_phase)
                        murc_pkg::PH_SEEK: begin
                            if (is_comma) begin
                                n_phase = murc_pkg::PH_AFTER_COMMA;
                            end
                        end
                        murc_pkg::PH_AFTER_COMMA: begin
                            priority if (is_blank) begin
                                n_phase = r_phase;
                            end else if (is_digit) begin
                                n_digit = i_byte[3:0];
                                n_phase = murc_pkg::PH_DIGIT;
                            end else begin
                                n_phase = murc_pkg::PH_REJECT;
                            end
                        end
                        murc_pkg::PH_DIGIT: begin
                            n_phase = (is_comma || is_blank) ? murc_pkg::PH_ACCEPT
                                                             : murc_pkg::PH_REJECT;
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end else if (i_start) begin
                n_capturing = 1'b1;
                n_count     = '0;
                n_phase     = murc_pkg::PH_SEEK;
                n_digit     = '0;
            end
        end
    end

    always_comb begin
        o_capturing    = r_capturing;
        o_status_valid = i_en && r_capturing && is_term &&
                         ((r_phase == murc_pkg::PH_DIGIT) || (r_phase == murc_pkg::PH_ACCEPT));
        o_call_status  = o_status_valid ? r_digit : 4'd0;
        o_status_end   = o_status_valid && (r_digit == murc_pkg::END_STATUS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capturing <= 1'b0;
            r_count     <= '0;
            r_phase     <= murc_pkg::PH_SEEK;
            r_digit     <= '0;
        end else begin
            r_capturing <= n_capturing;
            r_count     <= n_count;
            r_phase     <= n_phase;
            r_digit     <= n_digit;
        end
    end

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status_valid |-> (r_digit <= 4'd9))
        else $error("status digit out of range");

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_capturing |-> (r_count == '0))
        else $error("capture count not cleared outside payload");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= murc_pkg::CNT_W'(murc_pkg::CAPTURE_BYTES - 1))
        else $error("capture count beyond payload limit");

endmodule

>>> hdl/modem_urc_byte_matcher_top.sv
// top level of the modem unsolicited result code byte matcher
// depends on murc_pkg, murc_matchers and murc_capture
//
// usage:
//   s_axis carries one received modem byte per beat in tdata[7:0].
//   m_axis returns exactly one result beat for every input beat:
//   tdata[0] ring seen, [1] hangup, [2] status valid, [6:3] call status.
//   a byte is held in an input register, then the payload parser and, outside
//   a payload, all five matchers update in the same cycle that the result is
//   loaded into the output register.
//   throughput: one byte per cycle, sustained while m_axis_tready stays high.
//   the input register takes one more byte while a result waits in the
//   output register; a stalled m_axis holds two bytes in the block,
//   and s_axis_tready drops until m_axis_tready returns.
//   reset clears both valid flags, all match positions and the parser;
//   the block is ready for bytes as soon as reset is released.
module modem_urc_byte_matcher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] ring_seen, [1] hangup,
                                        // [2] status_valid, [6:3] call_status, [7] zero
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid, n_out_valid;
    logic       r_ring, r_ended, r_status_valid;
    logic [3:0] r_status;

    logic                 adv;
    logic                 capturing;
    logic                 status_valid;
    logic [3:0]           call_status;
    logic                 status_end;
    murc_pkg::t_match_evt evt;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    murc_matchers u_matchers (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv && !capturing),
        .i_byte  (r_in_byte),
        .o_evt   (evt)
    );

    murc_capture u_capture (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (adv),
        .i_byte         (r_in_byte),
        .i_start        (evt.callstat),
        .o_capturing    (capturing),
        .o_status_valid (status_valid),
        .o_call_status  (call_status),
        .o_status_end   (status_end)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (s_axis_tvalid && s_axis_tready) begin
            n_in_valid = 1'b1;
        end else if (adv) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (adv) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (adv) begin
            r_ring         <= evt.ring;
            r_ended        <= evt.nocarrier || status_end;
            r_status_valid <= status_valid;
            r_status       <= call_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_status, r_status_valid, r_ended, r_ring};

    a_ring_vs_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_ring && r_status_valid))
        else $error("ring and call status reported on the same beat");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(m_axis_tdata)))
        else $error("pending result lost under stall");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are full");

endmodule
